@@ rtl/network_impairment_emulator_assert.svh @@
// assertion macros for the network impairment emulator
// used by the top level only, needs clk and rst in scope
`ifndef NETWORK_IMPAIRMENT_EMULATOR_ASSERT_SVH
`define NETWORK_IMPAIRMENT_EMULATOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define NIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define NIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/nie_pkg.sv @@
// shared types and constants for the network impairment emulator
// no dependencies
package nie_pkg;

  localparam int          DEF_QUEUE_DEPTH   = 64;
  localparam int          DEF_TIME_BITS     = 48;
  localparam int          DEF_FRACTION_BITS = 16;
  localparam logic [63:0] DEF_SEED_WORD     = 64'd0;

  localparam logic [63:0] GOLDEN_WORD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_WORD    = 64'h2545f4914f6cdd1d;
  localparam int          XS_A        = 12;
  localparam int          XS_B        = 25;
  localparam int          XS_C        = 27;
  localparam int          DRAW_DROP   = 11;
  localparam int          CHANCE_SH   = 21;
  localparam int          DELAY_BITS  = 35;

  typedef enum logic [1:0] {
    MODE_SUBMIT  = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_RECEIVE = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    RES_QUEUE_DROP = 3'd0,
    RES_LOSS_DROP  = 3'd1,
    RES_QUEUED     = 3'd2,
    RES_QUEUED_DUP = 3'd3,
    RES_DUP_DROP   = 3'd4,
    RES_DELIVERED  = 3'd5,
    RES_NONE_READY = 3'd6,
    RES_DONE       = 3'd7
  } res_code_t;

  typedef enum logic [2:0] {
    REG_LATENCY   = 3'd0,
    REG_JITTER    = 3'd1,
    REG_REORD_MAX = 3'd2,
    REG_LOSS      = 3'd3,
    REG_DUP       = 3'd4,
    REG_REORD     = 3'd5,
    REG_TPB       = 3'd6,
    REG_QLIMIT    = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADVANCE,
    OP_CLEAR,
    OP_XS,
    OP_M0,
    OP_M1,
    OP_M2,
    OP_MUL_JIT,
    OP_MUL_RAMT,
    OP_MUL_SER,
    OP_SER_LINK,
    OP_SER_DONE,
    OP_DONE_NOW,
    OP_DELAY_INIT,
    OP_JIT_ADD,
    OP_RAMT_ADD,
    OP_WRITE,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_RD_LAST,
    OP_MOVE,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    PUR_LOSS,
    PUR_JIT,
    PUR_RORD,
    PUR_RAMT,
    PUR_DUP
  } purpose_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADVANCE,
    ST_CLEAR,
    ST_SUB_CAP,
    ST_LOSS_CHK,
    ST_SER_MUL,
    ST_SER_LINK,
    ST_SER_DONE,
    ST_DONE_NOW,
    ST_DELAY_INIT,
    ST_JIT_MUL,
    ST_JIT_ADD,
    ST_RORD_START,
    ST_RORD_CHK,
    ST_RAMT_MUL,
    ST_RAMT_ADD,
    ST_WRITE,
    ST_DUP_START,
    ST_DUP_CHK,
    ST_DRAW_XS,
    ST_DRAW_M0,
    ST_DRAW_M1,
    ST_DRAW_M2,
    ST_RCV_START,
    ST_RCV_SCAN,
    ST_RCV_TAIL,
    ST_RCV_CHK,
    ST_RCV_MOVE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [31:0] latency_ticks;
    logic [31:0] jitter_ticks;
    logic [31:0] reorder_max_ticks;
    logic [32:0] loss_chance;
    logic [32:0] duplicate_chance;
    logic [32:0] reorder_chance;
    logic [31:0] ticks_per_byte;
    logic [6:0]  queue_limit;
  } cfg_t;

  typedef struct packed {
    dp_op_t    op;
    res_code_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  count_zero;
    logic  scan_last;
    logic  late;
    logic  out_free;
    logic  loss_fire;
    logic  dup_fire;
    logic  rord_fire;
    logic  loss_zero;
    logic  dup_zero;
    logic  rord_zero;
    logic  jit_zero;
    logic  tpb_zero;
  } dp_stat_t;

endpackage

@@ rtl/nie_ctrl.sv @@
// sequencing state machine of the impairment emulator
// depends on nie_pkg, drives nie_dp through ctrl_cmd_t
module nie_ctrl
  import nie_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;
  purpose_t    purpose, purpose_next;
  res_code_t   code, code_next;
  logic        dup_pass, dup_pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      purpose  <= PUR_LOSS;
      code     <= RES_DONE;
      dup_pass <= 1'b0;
    end else begin
      state    <= state_next;
      purpose  <= purpose_next;
      code     <= code_next;
      dup_pass <= dup_pass_next;
    end
  end

  always_comb begin
    state_next    = state;
    purpose_next  = purpose;
    code_next     = code;
    dup_pass_next = dup_pass;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat.mode)
          MODE_SUBMIT:  state_next = ST_SUB_CAP;
          MODE_ADVANCE: state_next = ST_ADVANCE;
          MODE_RECEIVE: state_next = ST_RCV_START;
          MODE_CLEAR:   state_next = ST_CLEAR;
          default:      state_next = ST_IDLE;
        endcase
      end
      ST_ADVANCE, ST_CLEAR: begin
        code_next  = RES_DONE;
        state_next = ST_EMIT;
      end
      ST_SUB_CAP, ST_LOSS_CHK: begin
        dup_pass_next = 1'b0;
        if (state == ST_SUB_CAP && stat.full) begin
          code_next  = RES_QUEUE_DROP;
          state_next = ST_EMIT;
        end else if (state == ST_SUB_CAP && !stat.loss_zero) begin
          purpose_next = PUR_LOSS;
          state_next   = ST_DRAW_XS;
        end else if (state == ST_LOSS_CHK && stat.loss_fire) begin
          code_next  = RES_LOSS_DROP;
          state_next = ST_EMIT;
        end else if (stat.tpb_zero) begin
          state_next = ST_DONE_NOW;
        end else begin
          state_next = ST_SER_MUL;
        end
      end
      ST_SER_MUL:  state_next = ST_SER_LINK;
      ST_SER_LINK: state_next = ST_SER_DONE;
      ST_SER_DONE, ST_DONE_NOW: state_next = ST_DELAY_INIT;
      ST_DELAY_INIT: begin
        if (stat.jit_zero) begin
          state_next = ST_RORD_START;
        end else begin
          purpose_next = PUR_JIT;
          state_next   = ST_DRAW_XS;
        end
      end
      ST_JIT_MUL: state_next = ST_JIT_ADD;
      ST_JIT_ADD: state_next = ST_RORD_START;
      ST_RORD_START: begin
        if (stat.rord_zero) begin
          state_next = ST_WRITE;
        end else begin
          purpose_next = PUR_RORD;
          state_next   = ST_DRAW_XS;
        end
      end
      ST_RORD_CHK: begin
        if (stat.rord_fire) begin
          purpose_next = PUR_RAMT;
          state_next   = ST_DRAW_XS;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_RAMT_MUL: state_next = ST_RAMT_ADD;
      ST_RAMT_ADD: state_next = ST_WRITE;
      ST_WRITE: begin
        if (dup_pass) begin
          code_next  = RES_QUEUED_DUP;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DUP_START;
        end
      end
      ST_DUP_START: begin
        if (stat.dup_zero) begin
          code_next  = RES_QUEUED;
          state_next = ST_EMIT;
        end else begin
          purpose_next = PUR_DUP;
          state_next   = ST_DRAW_XS;
        end
      end
      ST_DUP_CHK: begin
        if (!stat.dup_fire) begin
          code_next  = RES_QUEUED;
          state_next = ST_EMIT;
        end else if (stat.full) begin
          code_next  = RES_DUP_DROP;
          state_next = ST_EMIT;
        end else begin
          dup_pass_next = 1'b1;
          state_next    = ST_DELAY_INIT;
        end
      end
      ST_DRAW_XS: state_next = ST_DRAW_M0;
      ST_DRAW_M0: state_next = ST_DRAW_M1;
      ST_DRAW_M1: state_next = ST_DRAW_M2;
      ST_DRAW_M2: begin
        unique case (purpose)
          PUR_LOSS: state_next = ST_LOSS_CHK;
          PUR_JIT:  state_next = ST_JIT_MUL;
          PUR_RORD: state_next = ST_RORD_CHK;
          PUR_RAMT: state_next = ST_RAMT_MUL;
          PUR_DUP:  state_next = ST_DUP_CHK;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_RCV_START: begin
        if (stat.count_zero) begin
          code_next  = RES_NONE_READY;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_RCV_SCAN;
        end
      end
      ST_RCV_SCAN: begin
        if (stat.scan_last) state_next = ST_RCV_TAIL;
      end
      ST_RCV_TAIL: state_next = ST_RCV_CHK;
      ST_RCV_CHK: begin
        if (stat.late) begin
          code_next  = RES_NONE_READY;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_RCV_MOVE;
        end
      end
      ST_RCV_MOVE: begin
        code_next  = RES_DELIVERED;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmd.op    = OP_NONE;
    cmd.code  = code;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) cmd.op = OP_LOAD;
      end
      ST_ADVANCE:    cmd.op = OP_ADVANCE;
      ST_CLEAR:      cmd.op = OP_CLEAR;
      ST_SER_MUL:    cmd.op = OP_MUL_SER;
      ST_SER_LINK:   cmd.op = OP_SER_LINK;
      ST_SER_DONE:   cmd.op = OP_SER_DONE;
      ST_DONE_NOW:   cmd.op = OP_DONE_NOW;
      ST_DELAY_INIT: cmd.op = OP_DELAY_INIT;
      ST_JIT_MUL:    cmd.op = OP_MUL_JIT;
      ST_JIT_ADD:    cmd.op = OP_JIT_ADD;
      ST_RAMT_MUL:   cmd.op = OP_MUL_RAMT;
      ST_RAMT_ADD:   cmd.op = OP_RAMT_ADD;
      ST_WRITE:      cmd.op = OP_WRITE;
      ST_DRAW_XS:    cmd.op = OP_XS;
      ST_DRAW_M0:    cmd.op = OP_M0;
      ST_DRAW_M1:    cmd.op = OP_M1;
      ST_DRAW_M2:    cmd.op = OP_M2;
      ST_RCV_START:  cmd.op = OP_SCAN_INIT;
      ST_RCV_SCAN:   cmd.op = OP_SCAN;
      ST_RCV_CHK:    cmd.op = OP_RD_LAST;
      ST_RCV_MOVE:   cmd.op = OP_MOVE;
      ST_EMIT: begin
        if (stat.out_free) cmd.op = OP_EMIT;
      end
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ rtl/nie_dp.sv @@
// datapath: generator, shared multiplier, time keeping, entry store, result register
// depends on nie_pkg, commanded by nie_ctrl
module nie_dp
  import nie_pkg::*;
#(
  parameter int          QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int          TIME_BITS     = DEF_TIME_BITS,
  parameter int          FRACTION_BITS = DEF_FRACTION_BITS,
  parameter logic [63:0] SEED_WORD     = DEF_SEED_WORD
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  cfg_t                 cfg,
  input  logic [1:0]           mode,
  input  logic [7:0]           flow,
  input  logic [31:0]          sequence_req,
  input  logic [15:0]          byte_length,
  input  logic [15:0]          buffer_tag,
  input  logic [31:0]          delta_ticks,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [2:0]           status,
  output logic [7:0]           flow_out,
  output logic [31:0]          sequence_out,
  output logic [15:0]          length_out,
  output logic [15:0]          tag_out,
  output logic [TIME_BITS-1:0] queued_time,
  output logic [TIME_BITS-1:0] delivered_time,
  output logic [6:0]           occupancy
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [64:0] TMAX65 = (65'(1) << TIME_BITS) - 65'(1);
  localparam logic [63:0] TMAX64 = TMAX65[63:0];

  // latched request
  mode_t       mode_q;
  logic [7:0]  flow_q;
  logic [31:0] seq_q;
  logic [15:0] len_q;
  logic [15:0] tag_q;
  logic [31:0] delta_q;

  // arithmetic state
  logic [63:0]            rng;
  logic [63:0]            word;
  logic [63:0]            prod;
  logic [TIME_BITS-1:0]   cur_time;
  logic [63:0]            link_free;
  logic [63:0]            arrival;
  logic [CW-1:0]          count;
  logic [TIME_BITS-1:0]   done_t;
  logic [DELAY_BITS-1:0]  delay;

  // entry store
  logic [TIME_BITS-1:0] mem_ready  [QUEUE_DEPTH];
  logic [63:0]          mem_order  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] mem_submit [QUEUE_DEPTH];
  logic [31:0]          mem_seq    [QUEUE_DEPTH];
  logic [39:0]          mem_desc   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] rd_ready, rd_submit, wr_ready, wr_submit;
  logic [63:0]          rd_order, wr_order;
  logic [31:0]          rd_seq, wr_seq;
  logic [39:0]          rd_desc, wr_desc;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;

  // scan
  logic [AW-1:0]        idx, pend_idx, best_idx;
  logic                 pend, best_valid, take;
  logic [TIME_BITS-1:0] best_ready, best_submit;
  logic [63:0]          best_order;
  logic [31:0]          best_seq;
  logic [39:0]          best_desc;

  // combinational helpers
  logic [63:0]            xs1, xs2, xs3;
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            mul_p;
  logic [127:0]           fx_wide;
  logic [63:0]            fx_now, ser_start, link_sh;
  logic [64:0]            ser_sum, adv_sum, rdy_sum;
  logic [DELAY_BITS-1:0]  jit_sum;
  logic [TIME_BITS-1:0]   new_ready;
  logic [CW-1:0]          cap;
  logic [53:0]            draw_d;
  logic                   out_free;

  assign xs1 = rng ^ (rng >> XS_A);
  assign xs2 = xs1 ^ (xs1 << XS_B);
  assign xs3 = xs2 ^ (xs2 >> XS_C);

  // shared 32x32 multiplier
  always_comb begin
    case (cmd.op)
      OP_M0:       begin mul_a = rng[31:0];  mul_b = MIX_WORD[31:0];       end
      OP_M1:       begin mul_a = rng[31:0];  mul_b = MIX_WORD[63:32];      end
      OP_M2:       begin mul_a = rng[63:32]; mul_b = MIX_WORD[31:0];       end
      OP_MUL_JIT:  begin mul_a = word[63:32]; mul_b = cfg.jitter_ticks;     end
      OP_MUL_RAMT: begin mul_a = word[63:32]; mul_b = cfg.reorder_max_ticks; end
      default:     begin mul_a = 32'(len_q);  mul_b = cfg.ticks_per_byte;   end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign fx_wide   = 128'(cur_time) << FRACTION_BITS;
  assign fx_now    = (|fx_wide[127:64]) ? '1 : fx_wide[63:0];
  assign ser_start = (fx_now > link_free) ? fx_now : link_free;
  assign ser_sum   = 65'(ser_start) + 65'(prod);
  assign link_sh   = link_free >> FRACTION_BITS;
  assign adv_sum   = 65'(cur_time) + 65'(delta_q);
  assign jit_sum   = delay + DELAY_BITS'(prod[63:31]);
  assign rdy_sum   = 65'(done_t) + 65'(delay);
  assign new_ready = (rdy_sum > TMAX65) ? TMAX64[TIME_BITS-1:0] : rdy_sum[TIME_BITS-1:0];

  // zero or oversized limit means the whole store
  assign cap = (cfg.queue_limit == 7'd0 || 32'(cfg.queue_limit) > 32'(QUEUE_DEPTH))
             ? CW'(QUEUE_DEPTH) : CW'(cfg.queue_limit);

  assign draw_d   = 54'(word[63:DRAW_DROP]);
  assign out_free = !rsp_valid || rsp_ready;

  assign take = pend && (!best_valid || rd_ready < best_ready ||
                (rd_ready == best_ready && rd_order < best_order));

  always_comb begin
    stat.mode       = mode_q;
    stat.full       = count >= cap;
    stat.count_zero = count == '0;
    stat.scan_last  = CW'(idx) == count - CW'(1);
    stat.late       = best_ready > cur_time;
    stat.out_free   = out_free;
    stat.loss_fire  = draw_d < (54'(cfg.loss_chance) << CHANCE_SH);
    stat.dup_fire   = draw_d < (54'(cfg.duplicate_chance) << CHANCE_SH);
    stat.rord_fire  = draw_d < (54'(cfg.reorder_chance) << CHANCE_SH);
    stat.loss_zero  = cfg.loss_chance == '0;
    stat.dup_zero   = cfg.duplicate_chance == '0;
    stat.rord_zero  = cfg.reorder_chance == '0;
    stat.jit_zero   = cfg.jitter_ticks == '0;
    stat.tpb_zero   = cfg.ticks_per_byte == '0;
  end

  // store ports
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = count[AW-1:0];
    wr_ready  = new_ready;
    wr_order  = arrival;
    wr_submit = cur_time;
    wr_seq    = seq_q;
    wr_desc   = {flow_q, len_q, tag_q};
    rd_addr   = idx;
    if (cmd.op == OP_WRITE) begin
      wr_en = 1'b1;
    end else if (cmd.op == OP_MOVE) begin
      wr_en     = 1'b1;
      wr_addr   = best_idx;
      wr_ready  = rd_ready;
      wr_order  = rd_order;
      wr_submit = rd_submit;
      wr_seq    = rd_seq;
      wr_desc   = rd_desc;
    end
    if (cmd.op == OP_RD_LAST) rd_addr = AW'(count - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ready[wr_addr]  <= wr_ready;
      mem_order[wr_addr]  <= wr_order;
      mem_submit[wr_addr] <= wr_submit;
      mem_seq[wr_addr]    <= wr_seq;
      mem_desc[wr_addr]   <= wr_desc;
    end
    rd_ready  <= mem_ready[rd_addr];
    rd_order  <= mem_order[rd_addr];
    rd_submit <= mem_submit[rd_addr];
    rd_seq    <= mem_seq[rd_addr];
    rd_desc   <= mem_desc[rd_addr];
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rng       <= (SEED_WORD == 64'd0) ? GOLDEN_WORD : SEED_WORD;
      cur_time  <= '0;
      link_free <= '0;
      arrival   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
      best_valid <= 1'b0;
      idx       <= '0;
    end else begin
      pend <= cmd.op == OP_SCAN;
      if (take) best_valid <= 1'b1;
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (cmd.op)
        OP_ADVANCE: begin
          cur_time <= (adv_sum > TMAX65) ? TMAX64[TIME_BITS-1:0] : adv_sum[TIME_BITS-1:0];
        end
        OP_CLEAR: begin
          count     <= '0;
          link_free <= fx_now;
        end
        OP_XS:       rng <= xs3;
        OP_SER_LINK: link_free <= ser_sum[64] ? '1 : ser_sum[63:0];
        OP_WRITE: begin
          arrival <= arrival + 64'd1;
          count   <= count + CW'(1);
        end
        OP_SCAN_INIT: begin
          idx        <= '0;
          best_valid <= 1'b0;
        end
        OP_SCAN:  idx <= idx + AW'(1);
        OP_MOVE:  count <= count - CW'(1);
        OP_EMIT:  rsp_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_q  <= mode_t'(mode);
        flow_q  <= flow;
        seq_q   <= sequence_req;
        len_q   <= byte_length;
        tag_q   <= buffer_tag;
        delta_q <= delta_ticks;
      end
      OP_M0:       word <= mul_p;
      OP_M1, OP_M2: word[63:32] <= word[63:32] + mul_p[31:0];
      OP_MUL_JIT, OP_MUL_RAMT, OP_MUL_SER: prod <= mul_p;
      OP_SER_DONE: begin
        done_t <= (link_sh > TMAX64) ? TMAX64[TIME_BITS-1:0] : link_sh[TIME_BITS-1:0];
      end
      OP_DONE_NOW:   done_t <= cur_time;
      OP_DELAY_INIT: delay <= DELAY_BITS'(cfg.latency_ticks);
      OP_JIT_ADD: begin
        delay <= (jit_sum < DELAY_BITS'(cfg.jitter_ticks)) ? '0
               : jit_sum - DELAY_BITS'(cfg.jitter_ticks);
      end
      OP_RAMT_ADD: delay <= delay + DELAY_BITS'(prod[63:32]);
      OP_SCAN:     pend_idx <= idx;
      OP_EMIT: begin
        status    <= cmd.code;
        occupancy <= 7'(count);
        if (cmd.code == RES_DELIVERED) begin
          flow_out       <= best_desc[39:32];
          length_out     <= best_desc[31:16];
          tag_out        <= best_desc[15:0];
          sequence_out   <= best_seq;
          queued_time    <= best_submit;
          delivered_time <= best_ready;
        end else begin
          flow_out       <= '0;
          length_out     <= '0;
          tag_out        <= '0;
          sequence_out   <= '0;
          queued_time    <= '0;
          delivered_time <= '0;
        end
      end
      default: ;
    endcase
    if (take) begin
      best_idx    <= pend_idx;
      best_ready  <= rd_ready;
      best_order  <= rd_order;
      best_submit <= rd_submit;
      best_seq    <= rd_seq;
      best_desc   <= rd_desc;
    end
  end

endmodule

@@ rtl/network_impairment_emulator.sv @@
// network impairment emulator, top level: register port, controller and datapath
// depends on nie_pkg, nie_ctrl, nie_dp and network_impairment_emulator_assert.svh
// One request is worked at a time and answered with exactly one result. A submit
// runs through the shared 32x32 multiplier: every random draw is an xorshift step
// plus three partial products, serialization adds a multiply, a link update and a
// done-tick step, and each jitter or reorder amount takes one more multiply and an
// add. A receive scans the entry store through its single read port, one entry per
// cycle. Each request ends by waiting while a previous result is still not taken.
// A result waits in its output register while the next request is already accepted.
// Configuration is a 64-bit register port, register i at byte address 8*i, and must be
// written only while the block is idle; the block itself does not enforce this.
`include "network_impairment_emulator_assert.svh"

module network_impairment_emulator
  import nie_pkg::*;
#(
  parameter int          QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int          TIME_BITS     = DEF_TIME_BITS,
  parameter int          FRACTION_BITS = DEF_FRACTION_BITS,
  parameter logic [63:0] SEED_WORD     = DEF_SEED_WORD
) (
  input  logic                 clk,
  input  logic                 rst,
  // register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  // request channel
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [1:0]           mode,
  input  logic [7:0]           flow,
  input  logic [31:0]          sequence_req,
  input  logic [15:0]          byte_length,
  input  logic [15:0]          buffer_tag,
  input  logic [31:0]          delta_ticks,
  // result channel
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [2:0]           status,
  output logic [7:0]           flow_out,
  output logic [31:0]          sequence_out,
  output logic [15:0]          length_out,
  output logic [15:0]          tag_out,
  output logic [TIME_BITS-1:0] queued_time,
  output logic [TIME_BITS-1:0] delivered_time,
  output logic [6:0]           occupancy
);

  cfg_t      cfg;
  reg_idx_t  reg_idx;
  logic      reg_wr;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign reg_wr  = psel && penable && pwrite && pready;

  // configuration registers, all clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_LATENCY:   cfg.latency_ticks     <= pwdata[31:0];
        REG_JITTER:    cfg.jitter_ticks      <= pwdata[31:0];
        REG_REORD_MAX: cfg.reorder_max_ticks <= pwdata[31:0];
        REG_LOSS:      cfg.loss_chance       <= pwdata[32:0];
        REG_DUP:       cfg.duplicate_chance  <= pwdata[32:0];
        REG_REORD:     cfg.reorder_chance    <= pwdata[32:0];
        REG_TPB:       cfg.ticks_per_byte    <= pwdata[31:0];
        REG_QLIMIT:    cfg.queue_limit       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_LATENCY:   prdata = 64'(cfg.latency_ticks);
      REG_JITTER:    prdata = 64'(cfg.jitter_ticks);
      REG_REORD_MAX: prdata = 64'(cfg.reorder_max_ticks);
      REG_LOSS:      prdata = 64'(cfg.loss_chance);
      REG_DUP:       prdata = 64'(cfg.duplicate_chance);
      REG_REORD:     prdata = 64'(cfg.reorder_chance);
      REG_TPB:       prdata = 64'(cfg.ticks_per_byte);
      REG_QLIMIT:    prdata = 64'(cfg.queue_limit);
      default:       prdata = '0;
    endcase
  end

  // sequencer: decides which datapath step runs each cycle
  nie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: generator, multiplier, clocks, entry store, result register
  nie_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .SEED_WORD     (SEED_WORD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg            (cfg),
    .mode           (mode),
    .flow           (flow),
    .sequence_req   (sequence_req),
    .byte_length    (byte_length),
    .buffer_tag     (buffer_tag),
    .delta_ticks    (delta_ticks),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .flow_out       (flow_out),
    .sequence_out   (sequence_out),
    .length_out     (length_out),
    .tag_out        (tag_out),
    .queued_time    (queued_time),
    .delivered_time (delivered_time),
    .occupancy      (occupancy)
  );

  // a packet never becomes ready before it was submitted
  `NIE_ASSERT_NOW(a_ready_after_submit, rsp_valid && status == RES_DELIVERED, delivered_time >= queued_time, "delivered packet ready before submission")
  // only a delivery carries packet fields
  `NIE_ASSERT_NOW(a_fields_zero, rsp_valid && status != RES_DELIVERED, flow_out == '0 && sequence_out == '0 && queued_time == '0 && delivered_time == '0, "packet fields set without delivery")
  // every result reports an occupancy within the store depth
  `NIE_ASSERT_NOW(a_occ_bound, rsp_valid, 32'(occupancy) <= 32'(QUEUE_DEPTH), "occupancy above store depth")
  // the sequencer accepts no request while it is working
  `NIE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request accepted while busy")

endmodule
